// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the ADC averaging and scaling block.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk_i, ignored while in reset.
`define AAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `AAS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/aas_pkg.sv =====
// Shared constants, types and microcode encodings of the ADC averaging and scaling block.
// No dependencies.
package aas_pkg;

  localparam int SampleWidth  = 12;
  localparam int SumWidth     = SampleWidth + 8;
  localparam int CntWidth     = 8;
  localparam int FullCode     = 2 ** SampleWidth - 1;
  localparam int VrefUv       = 3300000;
  // Microvolts per code, split into a whole part and a remainder over FullCode.
  localparam int UvWhole      = VrefUv / FullCode;
  localparam int UvFrac       = VrefUv % FullCode;

  localparam int NumWidth     = 32;
  localparam int DenWidth     = 16;
  localparam int BitsWidth    = 6;
  localparam int StepWidth    = 5;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 15;

  // Significant numerator bits of each division.
  localparam logic [BitsWidth-1:0] AvgDivBits   = BitsWidth'(SumWidth);
  localparam logic [BitsWidth-1:0] TempDivBits  = 6'd29;
  localparam logic [BitsWidth-1:0] LightDivBits = 6'd19;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_TEMP_CNT,
    REG_LIGHT_CNT,
    REG_V25,
    REG_SLOPE,
    REG_TEMP_MIN,
    REG_TEMP_MAX,
    REG_DARK,
    REG_BRIGHT
  } reg_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ACC,
    OP_DAVG,
    OP_WAIT,
    OP_AVG,
    OP_DFRAC,
    OP_FRAC,
    OP_UV,
    OP_DIFF,
    OP_DTEMP,
    OP_TEMP,
    OP_TRES,
    OP_LTEST,
    OP_DLIGHT,
    OP_LRES,
    OP_LEDGE
  } op_e;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_NOT_DONE,
    JMP_LIGHT,
    JMP_EDGE
  } jmp_e;

  typedef struct packed {
    op_e                  op;
    jmp_e                 jmp;
    logic [StepWidth-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic blk_done;
    logic is_light;
    logic light_edge;
    logic div_busy;
    logic out_full;
  } stat_t;

endpackage

// ===== rtl/aas_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// Depends on aas_pkg.
module aas_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [aas_pkg::NumWidth-1:0]  num_i,
  input  logic [aas_pkg::DenWidth-1:0]  den_i,
  input  logic [aas_pkg::BitsWidth-1:0] bits_i,
  output logic                         busy_o,
  output logic [aas_pkg::NumWidth-1:0]  quo_o
);
  import aas_pkg::*;

  logic [NumWidth-1:0]  quo_q, quo_d;
  logic [DenWidth-1:0]  rem_q, rem_d;
  logic [DenWidth-1:0]  den_q, den_d;
  logic [BitsWidth-1:0] cnt_q, cnt_d;
  logic [BitsWidth-1:0] shamt;
  logic [DenWidth:0]    part;
  logic [DenWidth+1:0]  trial;

  assign part  = {rem_q, quo_q[NumWidth-1]};
  assign trial = {1'b0, part} - {2'b00, den_q};
  assign shamt = BitsWidth'(NumWidth) - bits_i;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    if (start_i) begin
      // Left-align the numerator so only its significant bits are iterated.
      quo_d = num_i << shamt;
      rem_d = '0;
      den_d = den_i;
      cnt_d = bits_i;
    end else if (cnt_q != '0) begin
      if (!trial[DenWidth+1]) begin
        rem_d = trial[DenWidth-1:0];
      end else begin
        rem_d = part[DenWidth-1:0];
      end
      quo_d = {quo_q[NumWidth-2:0], ~trial[DenWidth+1]};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/aas_seq.sv =====
// Microcode sequencer: step counter, control store and jump logic.
// Depends on aas_pkg.
module aas_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  aas_pkg::stat_t  stat_i,
  output aas_pkg::ctrl_t  ctrl_o
);
  import aas_pkg::*;

  localparam logic [StepWidth-1:0] StIdle  = 5'd0;
  localparam logic [StepWidth-1:0] StLight = 5'd13;
  localparam logic [StepWidth-1:0] StEdge  = 5'd17;

  logic [StepWidth-1:0] step_q, step_d;
  ctrl_t                ctrl;
  logic                 hold;
  logic                 take;

  function automatic ctrl_t ucode(logic [StepWidth-1:0] step);
    ctrl_t w;
    w = '{op: OP_IDLE, jmp: JMP_ALWAYS, target: StIdle};
    case (step)
      5'd0:  w = '{op: OP_IDLE,   jmp: JMP_NONE,     target: StIdle};
      5'd1:  w = '{op: OP_ACC,    jmp: JMP_NOT_DONE, target: StIdle};
      5'd2:  w = '{op: OP_DAVG,   jmp: JMP_NONE,     target: StIdle};
      5'd3:  w = '{op: OP_WAIT,   jmp: JMP_NONE,     target: StIdle};
      5'd4:  w = '{op: OP_AVG,    jmp: JMP_LIGHT,    target: StLight};
      5'd5:  w = '{op: OP_DFRAC,  jmp: JMP_NONE,     target: StIdle};
      5'd6:  w = '{op: OP_FRAC,   jmp: JMP_NONE,     target: StIdle};
      5'd7:  w = '{op: OP_UV,     jmp: JMP_NONE,     target: StIdle};
      5'd8:  w = '{op: OP_DIFF,   jmp: JMP_NONE,     target: StIdle};
      5'd9:  w = '{op: OP_DTEMP,  jmp: JMP_NONE,     target: StIdle};
      5'd10: w = '{op: OP_WAIT,   jmp: JMP_NONE,     target: StIdle};
      5'd11: w = '{op: OP_TEMP,   jmp: JMP_NONE,     target: StIdle};
      5'd12: w = '{op: OP_TRES,   jmp: JMP_ALWAYS,   target: StIdle};
      5'd13: w = '{op: OP_LTEST,  jmp: JMP_EDGE,     target: StEdge};
      5'd14: w = '{op: OP_DLIGHT, jmp: JMP_NONE,     target: StIdle};
      5'd15: w = '{op: OP_WAIT,   jmp: JMP_NONE,     target: StIdle};
      5'd16: w = '{op: OP_LRES,   jmp: JMP_ALWAYS,   target: StIdle};
      5'd17: w = '{op: OP_LEDGE,  jmp: JMP_ALWAYS,   target: StIdle};
      default: w = '{op: OP_IDLE, jmp: JMP_ALWAYS,   target: StIdle};
    endcase
    return w;
  endfunction

  assign ctrl = ucode(step_q);

  always_comb begin
    hold = 1'b0;
    case (ctrl.op)
      OP_IDLE: hold = !stat_i.start;
      OP_WAIT: hold = stat_i.div_busy;
      OP_TRES, OP_LRES, OP_LEDGE: hold = stat_i.out_full;
      default: hold = 1'b0;
    endcase
  end

  always_comb begin
    take = 1'b0;
    case (ctrl.jmp)
      JMP_NONE:     take = 1'b0;
      JMP_ALWAYS:   take = 1'b1;
      JMP_NOT_DONE: take = !stat_i.blk_done;
      JMP_LIGHT:    take = stat_i.is_light;
      JMP_EDGE:     take = stat_i.light_edge;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      step_d = step_q;
    end else if (take) begin
      step_d = ctrl.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

// ===== rtl/adc_average_sensor_scaler.sv =====
// ADC averaging and sensor scaling: one transaction in at a time, at most one result per block.
// The wait for a result is set by the serial divider (one bit per cycle, 20 bits for the average):
// light at or beyond a threshold needs the average only, other light and temperature a second
// division. A sample that ends no block frees the input after its accumulate step; otherwise
// the next transaction is taken in the cycle after the result is written, later if it stalls.
// Reset (rst_ni, asynchronous, active low) clears sums, counts and control, loads defaults.
`include "assert_macros.svh"
module adc_average_sensor_scaler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [15:0]                      s_axis_tdata_i,  // [11:0] sample
  input  logic                             s_axis_tuser_i,  // [0] channel
  // Result stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [11:0] raw_average, [26:12] temp_centi, [33:27] light_percent, [34] out_of_range
  output logic [39:0]                      m_axis_tdata_o,
  output logic                             m_axis_tuser_o,  // [0] out_channel
  // Register write port.
  input  logic                             cfg_we_i,
  input  logic [aas_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [aas_pkg::CfgDataWidth-1:0] cfg_wdata_i
);
  import aas_pkg::*;

  // Configuration registers.
  logic [CntWidth-1:0]    tcnt_q, lcnt_q;
  logic [11:0]            v25_q;
  logic [13:0]            slope_q;
  logic signed [14:0]     tmin_q, tmax_q;
  logic [11:0]            dark_q, bright_q;

  // Per-channel accumulators.
  logic [SumWidth-1:0]    sum_q [2];
  logic [SumWidth-1:0]    sum_d [2];
  logic [CntWidth-1:0]    cnt_q [2];
  logic [CntWidth-1:0]    cnt_d [2];

  // Working registers of the datapath.
  logic                   ch_q;
  logic [SampleWidth-1:0] smp_q;
  logic [11:0]            avg_q, avg_d;
  logic signed [31:0]     acc_q, acc_d;
  logic                   neg_q, neg_d;

  // Result register; it parts the sequencer from the result stream.
  logic                   ovalid_q, ovalid_d;
  logic                   och_q, och_d;
  logic [11:0]            oavg_q, oavg_d;
  logic [14:0]            otemp_q, otemp_d;
  logic [6:0]             opct_q, opct_d;
  logic                   oor_q, oor_d;

  ctrl_t                  ctrl;
  stat_t                  stat;

  logic                   div_start;
  logic [NumWidth-1:0]    div_num;
  logic [DenWidth-1:0]    div_den;
  logic [BitsWidth-1:0]   div_bits;
  logic                   div_busy;
  logic [NumWidth-1:0]    div_quo;

  logic                   in_acc;
  logic                   out_full;
  logic                   res_wr;
  logic [SumWidth-1:0]    cur_sum;
  logic [CntWidth-1:0]    cur_cnt;
  logic [CntWidth-1:0]    new_cnt;
  logic [CntWidth-1:0]    target;
  logic                   blk_done;
  logic                   light_edge;
  logic signed [31:0]     scaled;
  logic signed [31:0]     tmin_x, tmax_x;
  logic [SampleWidth:0]   frac_rem;
  logic [SampleWidth:0]   frac_quo;

  assign s_axis_tready_o = ctrl.op == OP_IDLE;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_full        = ovalid_q && !m_axis_tready_i;
  assign res_wr          = (ctrl.op == OP_TRES || ctrl.op == OP_LRES ||
                            ctrl.op == OP_LEDGE) && !out_full;

  // Block end: the count reached the target (zero acts as one) or wrapped.
  assign cur_sum  = sum_q[ch_q];
  assign cur_cnt  = cnt_q[ch_q];
  assign new_cnt  = cur_cnt + 1'b1;
  assign target   = ch_q ? lcnt_q : tcnt_q;
  assign blk_done = (new_cnt == '0) ||
                    (new_cnt >= ((target == '0) ? CntWidth'(1) : target));

  assign light_edge = (avg_q >= dark_q) || (avg_q <= bright_q);

  assign scaled = acc_q * 32'sd100;
  assign tmin_x = 32'(tmin_q);
  assign tmax_x = 32'(tmax_q);

  // Division of the product held in acc_q by FullCode = 2^SampleWidth - 1. With the high
  // half as a first quotient the remainder is low half plus high half, which is below
  // twice FullCode plus one, so at most two compare steps finish the quotient.
  assign frac_rem = {1'b0, acc_q[SampleWidth-1:0]} +
                    {1'b0, acc_q[2*SampleWidth-1:SampleWidth]};
  assign frac_quo = {1'b0, acc_q[2*SampleWidth-1:SampleWidth]} +
                    ((frac_rem >= (SampleWidth+1)'(2 * FullCode)) ? (SampleWidth+1)'(2) :
                     (frac_rem >= (SampleWidth+1)'(FullCode))     ? (SampleWidth+1)'(1) :
                                                                    (SampleWidth+1)'(0));

  assign stat = '{start: in_acc, blk_done: blk_done, is_light: ch_q,
                  light_edge: light_edge, div_busy: div_busy, out_full: out_full};

  aas_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  aas_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .bits_i  (div_bits),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // Datapath actions selected by the current control word.
  always_comb begin
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    avg_d     = avg_q;
    acc_d     = acc_q;
    neg_d     = neg_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_bits  = '0;
    ovalid_d  = ovalid_q && !m_axis_tready_i;
    och_d     = och_q;
    oavg_d    = oavg_q;
    otemp_d   = otemp_q;
    opct_d    = opct_q;
    oor_d     = oor_q;
    case (ctrl.op)
      OP_ACC: begin
        sum_d[ch_q] = cur_sum + SumWidth'(smp_q);
        cnt_d[ch_q] = new_cnt;
      end
      OP_DAVG: begin
        // A wrapped count stands for 256 gathered samples.
        div_start   = 1'b1;
        div_num     = NumWidth'(cur_sum);
        div_den     = DenWidth'({cur_cnt == '0, cur_cnt});
        div_bits    = AvgDivBits;
        sum_d[ch_q] = '0;
        cnt_d[ch_q] = '0;
      end
      OP_AVG: begin
        avg_d = div_quo[11:0];
      end
      OP_DFRAC: begin
        // Remainder part of the microvolt product, reduced by FullCode in the next step.
        acc_d = signed'(32'(avg_q) * 32'(UvFrac));
      end
      OP_FRAC: begin
        acc_d = signed'(32'(frac_quo));
      end
      OP_UV: begin
        acc_d = acc_q + signed'(32'(avg_q) * 32'(UvWhole));
      end
      OP_DIFF: begin
        acc_d = acc_q - signed'(32'(v25_q) * 32'd1000);
      end
      OP_DTEMP: begin
        // Divide the magnitude so the quotient truncates toward zero.
        div_start = 1'b1;
        neg_d     = scaled[31];
        div_num   = scaled[31] ? unsigned'(-scaled) : unsigned'(scaled);
        div_den   = DenWidth'((slope_q == '0) ? 14'd1 : slope_q);
        div_bits  = TempDivBits;
      end
      OP_TEMP: begin
        acc_d = (neg_q ? -signed'(div_quo) : signed'(div_quo)) + 32'sd2500;
      end
      OP_TRES: begin
        if (res_wr) begin
          ovalid_d = 1'b1;
          och_d    = 1'b0;
          oavg_d   = avg_q;
          opct_d   = '0;
          if (acc_q < tmin_x) begin
            otemp_d = tmin_q;
            oor_d   = 1'b1;
          end else if (acc_q > tmax_x) begin
            otemp_d = tmax_q;
            oor_d   = 1'b1;
          end else begin
            otemp_d = acc_q[14:0];
            oor_d   = 1'b0;
          end
        end
      end
      OP_DLIGHT: begin
        div_start = 1'b1;
        div_num   = 32'(dark_q - avg_q) * 32'd100;
        div_den   = DenWidth'(dark_q - bright_q);
        div_bits  = LightDivBits;
      end
      OP_LRES: begin
        if (res_wr) begin
          ovalid_d = 1'b1;
          och_d    = 1'b1;
          oavg_d   = avg_q;
          otemp_d  = '0;
          opct_d   = div_quo[6:0];
          oor_d    = 1'b0;
        end
      end
      OP_LEDGE: begin
        if (res_wr) begin
          ovalid_d = 1'b1;
          och_d    = 1'b1;
          oavg_d   = avg_q;
          otemp_d  = '0;
          if (avg_q >= dark_q) begin
            opct_d = '0;
            oor_d  = avg_q > dark_q;
          end else begin
            opct_d = 7'd100;
            oor_d  = avg_q < bright_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state, accumulators and registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcnt_q   <= 8'd10;
      lcnt_q   <= 8'd10;
      v25_q    <= 12'd760;
      slope_q  <= 14'd2500;
      tmin_q   <= -15'sd4000;
      tmax_q   <= 15'sd12500;
      dark_q   <= 12'd3500;
      bright_q <= 12'd200;
      sum_q    <= '{default: '0};
      cnt_q    <= '{default: '0};
      ovalid_q <= 1'b0;
    end else begin
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_TEMP_CNT:  tcnt_q   <= cfg_wdata_i[CntWidth-1:0];
          REG_LIGHT_CNT: lcnt_q   <= cfg_wdata_i[CntWidth-1:0];
          REG_V25:       v25_q    <= cfg_wdata_i[11:0];
          REG_SLOPE:     slope_q  <= cfg_wdata_i[13:0];
          REG_TEMP_MIN:  tmin_q   <= signed'(cfg_wdata_i[14:0]);
          REG_TEMP_MAX:  tmax_q   <= signed'(cfg_wdata_i[14:0]);
          REG_DARK:      dark_q   <= cfg_wdata_i[11:0];
          REG_BRIGHT:    bright_q <= cfg_wdata_i[11:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q  <= s_axis_tuser_i;
      smp_q <= s_axis_tdata_i[SampleWidth-1:0];
    end
    avg_q   <= avg_d;
    acc_q   <= acc_d;
    neg_q   <= neg_d;
    och_q   <= och_d;
    oavg_q  <= oavg_d;
    otemp_q <= otemp_d;
    opct_q  <= opct_d;
    oor_q   <= oor_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tuser_o  = och_q;
  assign m_axis_tdata_o  = {5'b00000, oor_q, opct_q, otemp_q, oavg_q};

  // The divider is always finished before the sequencer returns to idle.
  `AAS_ASSERT(a_idle_div_quiet, s_axis_tready_o |-> !div_busy, "divider busy in idle")
  // A result written by the sequencer is presented on the next cycle.
  `AAS_ASSERT_NEXT(a_result_shown, res_wr, m_axis_tvalid_o, "result write lost")
  // A light result carries no temperature and a percentage of at most 100.
  `AAS_ASSERT(a_light_fields,
              m_axis_tvalid_o && m_axis_tuser_o |-> opct_q <= 7'd100 && otemp_q == '0,
              "bad light result")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for adc_average_sensor_scaler: per-channel averaging and
// temperature/light scaling, checked against an in-bench predictor result by result.
// Depends on aas_pkg (register index enum) and the adc_average_sensor_scaler RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aas_pkg::*;

  // Channel tags carried on tuser, on both streams.
  localparam logic CH_TEMP  = 1'b0;
  localparam logic CH_LIGHT = 1'b1;

  localparam int     MAX_IDLE        = 11;
  // Covers the slowest result (temperature) with margin.
  localparam int     DRAIN_CYCLES    = 120;
  // Longest correct stretch without a transaction is roughly a drain, the writes, a gap and a result.
  localparam int     WATCHDOG_LIMIT  = 4000;
  localparam int     RANDOM_PHASES   = 10;
  localparam int     ITEMS_PER_PHASE = 71;
  localparam int     MAX_REPORTS     = 50;
  localparam longint FULL_SCALE_CODE = 4095;
  localparam longint VREF_MICROVOLTS = 3300000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;   // [11:0] sample
  logic        s_axis_tuser_i;   // [0] channel
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // [11:0] raw_average, [26:12] temp_centi, [33:27] light_percent, [34] out_of_range
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;   // [0] out_channel
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_wdata_i;

  // One finished block as the result stream should present it.
  typedef struct {
    logic               channel;
    logic [11:0]        average;
    logic signed [14:0] temp_centi;
    logic [6:0]         light_percent;
    logic               out_of_range;
  } reading_t;

  reading_t expected_readings[$];

  // Predictor copy of the register file.
  logic [7:0]         cfg_temp_count;
  logic [7:0]         cfg_light_count;
  logic [11:0]        cfg_v25_mv;
  logic [13:0]        cfg_slope;
  logic signed [14:0] cfg_temp_min;
  logic signed [14:0] cfg_temp_max;
  logic [11:0]        cfg_dark;
  logic [11:0]        cfg_bright;

  // Predictor copy of the per-channel accumulators.
  logic [19:0] block_sum[2];
  logic [7:0]  block_count[2];

  int mismatch_count;
  int idle_cycles;
  int rx_stall;
  bit no_idle;

  adc_average_sensor_scaler u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Number of idle cycles before the next transaction on either side. During a
  // burst stretch both sides run flat out.
  function automatic int draw_idle();
    return no_idle ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  // Adds one accepted sample to its channel. When the channel's block is complete
  // the average is scaled and the reading is queued; otherwise nothing is queued.
  function automatic void predict_reading(input logic ch, input logic [11:0] sample);
    logic [7:0]  target;
    int unsigned avg;
    longint      uv;
    longint      divisor;
    longint      centi;
    reading_t    r;
    target = (ch == CH_LIGHT) ? cfg_light_count : cfg_temp_count;
    // A count register of zero behaves as one.
    if (target == 0) target = 8'd1;
    block_sum[ch]   = block_sum[ch] + sample;
    block_count[ch] = block_count[ch] + 8'd1;
    // The block also ends when the register was lowered below the count already held.
    if (block_count[ch] != 0 && block_count[ch] < target) return;
    if (block_count[ch] == 0) avg = block_sum[ch] / 256;
    else avg = block_sum[ch] / block_count[ch];
    block_sum[ch]   = '0;
    block_count[ch] = '0;

    r = '{default: '0};
    r.channel = ch;
    r.average = avg[11:0];
    if (ch == CH_TEMP) begin
      uv      = longint'(avg) * VREF_MICROVOLTS / FULL_SCALE_CODE;
      divisor = (cfg_slope == 0) ? 64'sd1 : longint'(cfg_slope);
      // SystemVerilog division truncates toward zero, as the block does.
      centi = ((uv - longint'(cfg_v25_mv) * 1000) * 100) / divisor + 2500;
      // The lower limit is tested first, so it wins where crossed limits both apply.
      if (centi < longint'(cfg_temp_min)) begin
        centi = longint'(cfg_temp_min);
        r.out_of_range = 1'b1;
      end else if (centi > longint'(cfg_temp_max)) begin
        centi = longint'(cfg_temp_max);
        r.out_of_range = 1'b1;
      end
      r.temp_centi = centi[14:0];
    end else begin
      if (avg >= cfg_dark) begin
        r.light_percent = 7'd0;
        r.out_of_range  = (avg > cfg_dark);
      end else if (avg <= cfg_bright) begin
        // Also covers bright set at or above dark.
        r.light_percent = 7'd100;
        r.out_of_range  = (avg < cfg_bright);
      end else begin
        r.light_percent = 7'((100 * (cfg_dark - avg)) / (cfg_dark - cfg_bright));
      end
    end
    expected_readings.push_back(r);
  endfunction

  // Offers one sample after a random gap and waits for the transaction to complete.
  // Entered and left at a falling edge; valid is only lowered when a gap is drawn,
  // so back-to-back transactions never see two assignments in one step.
  task automatic send_sample(input logic ch, input logic [11:0] sample);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0, sample};
    s_axis_tuser_i  <= ch;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_reading(ch, sample);
    @(negedge clk_i);
  endtask

  // Stops the input stream and waits until every queued reading has arrived and
  // the block has had time to finish any work that produces no result.
  task automatic wait_for_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Register write, only issued while the block is idle. Raising and lowering the enable
  // fall in separate steps, which keeps a single assignment to it in each step.
  task automatic write_reg(input reg_e idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[CfgDataWidth-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_TEMP_CNT:  cfg_temp_count  = value[7:0];
      REG_LIGHT_CNT: cfg_light_count = value[7:0];
      REG_V25:       cfg_v25_mv      = value[11:0];
      REG_SLOPE:     cfg_slope       = value[13:0];
      REG_TEMP_MIN:  cfg_temp_min    = value[14:0];
      REG_TEMP_MAX:  cfg_temp_max    = value[14:0];
      REG_DARK:      cfg_dark        = value[11:0];
      REG_BRIGHT:    cfg_bright      = value[11:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Edge values a sixth of the time each, otherwise uniform.
  function automatic int pick_in(input int lo, input int hi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return int'($urandom_range(hi, lo));
    endcase
  endfunction

  // Samples lean towards the band where a typical sensor reads room temperatures,
  // with the code extremes mixed in.
  function automatic logic [11:0] random_sample();
    case ($urandom_range(0, 9))
      0:             return 12'h000;
      1:             return 12'hFFF;
      2, 3, 4, 5:    return 12'($urandom_range(600, 1500));
      default:       return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic int random_count();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 255;
      2:       return 1;
      default: return int'($urandom_range(1, 8));
    endcase
  endfunction

  // Random traffic with the register values left as they come out of reset.
  task automatic test_reset_settings();
    repeat (40) send_sample(logic'($urandom_range(0, 1)), random_sample());
    wait_for_idle();
  endtask

  // One sample per result: code extremes on both channels and the light thresholds
  // hit exactly and missed by one.
  task automatic test_field_extremes();
    logic [11:0] temp_codes[5]  = '{12'h000, 12'hFFF, 12'h555, 12'hAAA, 12'd943};
    logic [11:0] light_codes[7] = '{12'h000, 12'hFFF, 12'd3500, 12'd3501,
                                    12'd200, 12'd199, 12'd1850};
    write_reg(REG_TEMP_CNT, 1);
    write_reg(REG_LIGHT_CNT, 1);
    foreach (temp_codes[i]) send_sample(CH_TEMP, temp_codes[i]);
    foreach (light_codes[i]) send_sample(CH_LIGHT, light_codes[i]);
    wait_for_idle();
  endtask

  task automatic test_special_cases();
    // A zero sample count must behave as a count of one.
    write_reg(REG_TEMP_CNT, 0);
    write_reg(REG_LIGHT_CNT, 0);
    send_sample(CH_TEMP, 12'd1000);
    send_sample(CH_LIGHT, 12'd2000);
    wait_for_idle();

    // Zero slope behaves as one; limits opened to the full register range.
    write_reg(REG_SLOPE, 0);
    write_reg(REG_TEMP_MIN, -16384);
    write_reg(REG_TEMP_MAX, 16383);
    send_sample(CH_TEMP, 12'd943);
    wait_for_idle();

    // Minimum above maximum: the lower test wins.
    write_reg(REG_SLOPE, 2500);
    write_reg(REG_TEMP_MIN, 5000);
    write_reg(REG_TEMP_MAX, 0);
    send_sample(CH_TEMP, 12'd943);
    send_sample(CH_TEMP, 12'hFFF);
    send_sample(CH_TEMP, 12'h000);
    wait_for_idle();

    // Bright threshold at or above dark: anything below dark reads full scale.
    write_reg(REG_DARK, 1000);
    write_reg(REG_BRIGHT, 3000);
    send_sample(CH_LIGHT, 12'd500);
    send_sample(CH_LIGHT, 12'd2000);
    send_sample(CH_LIGHT, 12'd1000);
    wait_for_idle();

    // Count lowered in the middle of a block: the next sample closes it and the
    // average divides by the four samples actually gathered.
    write_reg(REG_TEMP_CNT, 6);
    send_sample(CH_TEMP, 12'd800);
    send_sample(CH_TEMP, 12'd900);
    send_sample(CH_TEMP, 12'd1001);
    wait_for_idle();
    write_reg(REG_TEMP_CNT, 2);
    send_sample(CH_TEMP, 12'd1203);
    wait_for_idle();
  endtask

  // Phases of random samples, each under freshly drawn registers. With even odds
  // a phase draws plausible sensor settings so that results land between the
  // limits, or draws on every value the registers can hold. Accumulators are not
  // cleared between phases, so count changes in mid-block arise here as well.
  task automatic test_random_phases();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      write_reg(REG_TEMP_CNT, random_count());
      write_reg(REG_LIGHT_CNT, random_count());
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_V25, int'($urandom_range(600, 900)));
        write_reg(REG_SLOPE, int'($urandom_range(1500, 3500)));
        write_reg(REG_TEMP_MIN, -int'($urandom_range(0, 5500)));
        write_reg(REG_TEMP_MAX, int'($urandom_range(5000, 15000)));
        write_reg(REG_DARK, int'($urandom_range(2500, 4095)));
        write_reg(REG_BRIGHT, int'($urandom_range(0, 1200)));
      end else begin
        write_reg(REG_V25, pick_in(0, 4095));
        write_reg(REG_SLOPE, pick_in(0, 16383));
        write_reg(REG_TEMP_MIN, pick_in(0, 32767));
        write_reg(REG_TEMP_MAX, pick_in(0, 32767));
        write_reg(REG_DARK, pick_in(0, 4095));
        write_reg(REG_BRIGHT, pick_in(0, 4095));
      end
      repeat (ITEMS_PER_PHASE) send_sample(logic'($urandom_range(0, 1)), random_sample());
      wait_for_idle();
    end
    no_idle = 1'b0;
  endtask

  // Result sink: ready follows a stall drawn afresh after every transaction.
  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Each result transaction is compared field by field with the oldest reading.
  always @(posedge clk_i) begin : check_results
    reading_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      rx_stall = draw_idle();
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, channel %0d average %0d",
                                  m_axis_tuser_o, m_axis_tdata_o[11:0]));
      end else begin
        want = expected_readings.pop_front();
        if (m_axis_tuser_o !== want.channel)
          report_mismatch($sformatf("out_channel expected %0d got %0d",
                                    want.channel, m_axis_tuser_o));
        if (m_axis_tdata_o[11:0] !== want.average)
          report_mismatch($sformatf("raw_average expected %0d got %0d",
                                    want.average, m_axis_tdata_o[11:0]));
        if (m_axis_tdata_o[26:12] !== want.temp_centi)
          report_mismatch($sformatf("temp_centi expected %0d got %0d",
                                    want.temp_centi, $signed(m_axis_tdata_o[26:12])));
        if (m_axis_tdata_o[33:27] !== want.light_percent)
          report_mismatch($sformatf("light_percent expected %0d got %0d",
                                    want.light_percent, m_axis_tdata_o[33:27]));
        if (m_axis_tdata_o[34] !== want.out_of_range)
          report_mismatch($sformatf("out_of_range expected %0d got %0d",
                                    want.out_of_range, m_axis_tdata_o[34]));
      end
    end
  end

  // Watchdog: ends the run if neither stream completes a transaction for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CH_TEMP;
    m_axis_tready_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_TEMP_CNT;
    cfg_wdata_i     = '0;
    no_idle         = 1'b0;
    rx_stall        = 0;
    idle_cycles     = 0;
    mismatch_count  = 0;
    // Register defaults and cleared accumulators, as reset leaves the block.
    cfg_temp_count  = 8'd10;
    cfg_light_count = 8'd10;
    cfg_v25_mv      = 12'd760;
    cfg_slope       = 14'd2500;
    cfg_temp_min    = -15'sd4000;
    cfg_temp_max    = 15'sd12500;
    cfg_dark        = 12'd3500;
    cfg_bright      = 12'd200;
    block_sum       = '{default: '0};
    block_count     = '{default: '0};

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_settings();
    test_field_extremes();
    test_special_cases();
    test_random_phases();
    wait_for_idle();

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
